// ===== rtl/core/pal_pkg.sv =====
// Shared types and constants for the positional array list.
// Holds the transaction structs, code enums and the microcode ROM.
// No dependencies; every other file of the block uses it.
package pal_pkg;

  // Transaction payloads
  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  position;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [4:0]  length;
  } out_item_t;

  // Action and status codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_GET    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Configuration register map
  localparam logic [4:0] CAPACITY_RESET = 5'd16;
  localparam logic       REG_CAPACITY   = 1'b0;  // word select bit of paddr

  // Microcode fields
  typedef enum logic [1:0] {RD_NONE, RD_PREV, RD_NEXT, RD_POS} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_MOVE, WR_VALUE} wr_sel_t;
  typedef enum logic [2:0] {IDX_HOLD, IDX_COUNT, IDX_POS, IDX_INC, IDX_DEC} idx_op_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLEAR} cnt_op_t;
  typedef enum logic [2:0] {
    JMP_NEXT,        // fall through
    JMP_ALWAYS,      // go to target
    JMP_IDX_AT_POS,  // go to target when index reached position
    JMP_SHIFT_DONE,  // go to target when no entry is left to pull down
    JMP_FINISH       // present result and stop
  } jmp_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    rd_sel_t rd;
    wr_sel_t wr;
    idx_op_t idx;
    cnt_op_t cnt;
    jmp_t    jmp;
    upc_t    target;
  } ctrl_word_t;

  // Program addresses
  localparam upc_t UPC_FINISH   = 4'd0;
  localparam upc_t UPC_INS_INIT = 4'd1;
  localparam upc_t UPC_INS_TEST = 4'd2;
  localparam upc_t UPC_INS_MOVE = 4'd3;
  localparam upc_t UPC_INS_PUT  = 4'd4;
  localparam upc_t UPC_GET      = 4'd5;
  localparam upc_t UPC_DEL_INIT = 4'd6;
  localparam upc_t UPC_DEL_TEST = 4'd7;
  localparam upc_t UPC_DEL_MOVE = 4'd8;
  localparam upc_t UPC_DEL_END  = 4'd9;
  localparam upc_t UPC_CLEAR    = 4'd10;

  localparam ctrl_word_t CW_NOP = '{
    rd: RD_NONE, wr: WR_NONE, idx: IDX_HOLD, cnt: CNT_HOLD,
    jmp: JMP_NEXT, target: UPC_FINISH
  };

  // Sequencer <-> datapath handshakes
  typedef struct packed {
    logic       accept;  // transaction taken this cycle
    logic       finish;  // last step, result goes out
    ctrl_word_t cw;
  } seq_ctl_t;

  typedef struct packed {
    logic start_err;   // incoming transaction fails its checks
    logic idx_at_pos;  // insert shift reached the target slot
    logic shift_done;  // delete shift reached the last entry
  } dp_flags_t;

  // Microcode ROM
  function automatic ctrl_word_t ucode_rom(input upc_t addr);
    ctrl_word_t cw;
    cw = CW_NOP;
    case (addr)
      UPC_FINISH: begin
        cw.jmp = JMP_FINISH;
      end
      UPC_INS_INIT: begin
        cw.idx = IDX_COUNT;
      end
      UPC_INS_TEST: begin
        cw.rd     = RD_PREV;
        cw.jmp    = JMP_IDX_AT_POS;
        cw.target = UPC_INS_PUT;
      end
      UPC_INS_MOVE: begin
        cw.wr     = WR_MOVE;
        cw.idx    = IDX_DEC;
        cw.jmp    = JMP_ALWAYS;
        cw.target = UPC_INS_TEST;
      end
      UPC_INS_PUT: begin
        cw.wr     = WR_VALUE;
        cw.cnt    = CNT_INC;
        cw.jmp    = JMP_ALWAYS;
        cw.target = UPC_FINISH;
      end
      UPC_GET: begin
        cw.rd     = RD_POS;
        cw.jmp    = JMP_ALWAYS;
        cw.target = UPC_FINISH;
      end
      UPC_DEL_INIT: begin
        cw.idx = IDX_POS;
      end
      UPC_DEL_TEST: begin
        cw.rd     = RD_NEXT;
        cw.jmp    = JMP_SHIFT_DONE;
        cw.target = UPC_DEL_END;
      end
      UPC_DEL_MOVE: begin
        cw.wr     = WR_MOVE;
        cw.idx    = IDX_INC;
        cw.jmp    = JMP_ALWAYS;
        cw.target = UPC_DEL_TEST;
      end
      UPC_DEL_END: begin
        cw.cnt    = CNT_DEC;
        cw.jmp    = JMP_ALWAYS;
        cw.target = UPC_FINISH;
      end
      UPC_CLEAR: begin
        cw.cnt    = CNT_CLEAR;
        cw.jmp    = JMP_ALWAYS;
        cw.target = UPC_FINISH;
      end
      default: begin
        cw.jmp = JMP_FINISH;
      end
    endcase
    return cw;
  endfunction

  // Program entry for an accepted transaction
  function automatic upc_t entry_point(input logic [1:0] action, input logic err);
    upc_t pc;
    pc = UPC_FINISH;
    if (!err) begin
      case (action)
        ACT_INSERT: pc = UPC_INS_INIT;
        ACT_GET:    pc = UPC_GET;
        ACT_DELETE: pc = UPC_DEL_INIT;
        ACT_CLEAR:  pc = UPC_CLEAR;
        default:    pc = UPC_FINISH;
      endcase
    end
    return pc;
  endfunction

endpackage

// ===== rtl/core/positional_array_list.sv =====
// Positional array list: insert/get/delete/clear on an ordered list of entries.
// The shift moves entries one at a time, each read in a test step and written in a
// move step of the microcode, through the memory's read and write ports; busy stays
// high until the result strobe, one item at a time.
// Synchronous active-low reset empties the list and sets capacity to 16; no clearing pass.
module positional_array_list #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  pal_pkg::in_item_t  in_item,
  // result channel
  output logic               out_valid,
  output pal_pkg::out_item_t out_item,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  pal_pkg::seq_ctl_t  ctl;
  pal_pkg::dp_flags_t flags;
  logic [4:0]         capacity_r;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= pal_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == pal_pkg::REG_CAPACITY)) begin
      capacity_r <= pwdata[4:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pal_pkg::REG_CAPACITY) ? {27'd0, capacity_r} : 32'd0;

  pal_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_item.action),
    .flags     (flags),
    .busy      (busy),
    .ctl       (ctl)
  );

  pal_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .capacity  (capacity_r),
    .ctl       (ctl),
    .flags     (flags),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/pal_sequencer.sv =====
// Microcode sequencer: step counter, ROM lookup and jump logic.
// Depends on pal_pkg for the control word, ROM and flag structs.
module pal_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_action,
  input  pal_pkg::dp_flags_t  flags,
  output logic                busy,
  output pal_pkg::seq_ctl_t   ctl
);

  logic              busy_r, busy_nxt;
  pal_pkg::upc_t     upc_r, upc_nxt;
  pal_pkg::ctrl_word_t cw;
  logic              accept;

  assign accept = start && !busy_r;
  assign cw     = busy_r ? pal_pkg::ucode_rom(upc_r) : pal_pkg::CW_NOP;

  // Next step selection
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      upc_nxt  = pal_pkg::entry_point(in_action, flags.start_err);
    end else if (busy_r) begin
      case (cw.jmp)
        pal_pkg::JMP_NEXT:       upc_nxt = upc_r + 4'd1;
        pal_pkg::JMP_ALWAYS:     upc_nxt = cw.target;
        pal_pkg::JMP_IDX_AT_POS: upc_nxt = flags.idx_at_pos ? cw.target : upc_r + 4'd1;
        pal_pkg::JMP_SHIFT_DONE: upc_nxt = flags.shift_done ? cw.target : upc_r + 4'd1;
        pal_pkg::JMP_FINISH: begin
          busy_nxt = 1'b0;
          upc_nxt  = pal_pkg::UPC_FINISH;
        end
        default: begin
          busy_nxt = 1'b0;
          upc_nxt  = pal_pkg::UPC_FINISH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= pal_pkg::UPC_FINISH;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  assign busy       = busy_r;
  assign ctl.accept = accept;
  assign ctl.finish = busy_r && (cw.jmp == pal_pkg::JMP_FINISH);
  assign ctl.cw     = cw;

endmodule

// ===== rtl/core/pal_datapath.sv =====
// Datapath: entry memory, length count, shift index and result register.
// Driven by the control word of pal_sequencer; depends on pal_pkg.
module pal_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pal_pkg::in_item_t   in_item,
  input  logic [4:0]          capacity,
  input  pal_pkg::seq_ctl_t   ctl,
  output pal_pkg::dp_flags_t  flags,
  output logic                out_valid,
  output pal_pkg::out_item_t  out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > 5) ? CW : 5;  // compare width for count vs 5-bit fields

  // Entry memory
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  // Per-transaction state
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         pos_r;
  logic [1:0]            act_r;
  pal_pkg::status_t      status_r;
  logic [DATA_WIDTH-1:0] val_r;

  logic                  out_valid_r;
  pal_pkg::out_item_t    out_item_r;

  // Input resize to storage width
  logic [63:0]           in_wide;
  logic [DATA_WIDTH-1:0] in_data;
  logic [63:0]           rd_wide;

  assign in_wide = 64'(in_item.entry_value);
  assign in_data = in_wide[DATA_WIDTH-1:0];
  assign rd_wide = 64'(rdata_r);

  // Admission checks on the incoming transaction
  logic [KW-1:0]    cnt_k, pos_k, cap_k, depth_k, eff_cap_k, pos_clamp_k;
  pal_pkg::status_t chk_status;

  assign cnt_k       = KW'(count_r);
  assign pos_k       = KW'(in_item.position);
  assign cap_k       = KW'(capacity);
  assign depth_k     = KW'(DEPTH);
  assign eff_cap_k   = (cap_k > depth_k) ? depth_k : cap_k;
  assign pos_clamp_k = (pos_k > cnt_k) ? cnt_k : pos_k;

  always_comb begin
    chk_status = pal_pkg::ST_OK;
    case (in_item.action)
      pal_pkg::ACT_INSERT: begin
        if (in_data == '0)
          chk_status = pal_pkg::ST_NULL;
        else if (cnt_k >= eff_cap_k)
          chk_status = pal_pkg::ST_FULL;
      end
      pal_pkg::ACT_GET, pal_pkg::ACT_DELETE: begin
        if (pos_k >= cnt_k)
          chk_status = pal_pkg::ST_RANGE;
      end
      default: chk_status = pal_pkg::ST_OK;
    endcase
  end

  // Loop condition flags
  logic idx_at_pos, shift_done;
  assign idx_at_pos = (idx_r == pos_r);
  assign shift_done = ({1'b0, idx_r} + {{CW{1'b0}}, 1'b1}) >= {1'b0, count_r};

  assign flags.start_err  = (chk_status != pal_pkg::ST_OK);
  assign flags.idx_at_pos = idx_at_pos;
  assign flags.shift_done = shift_done;

  // Memory read address and enable
  logic [CW-1:0] raddr_c;
  logic          rd_en;
  always_comb begin
    raddr_c = pos_r;
    rd_en   = 1'b0;
    case (ctl.cw.rd)
      pal_pkg::RD_PREV: begin
        raddr_c = idx_r - {{(CW-1){1'b0}}, 1'b1};
        rd_en   = !idx_at_pos;
      end
      pal_pkg::RD_NEXT: begin
        raddr_c = idx_r + {{(CW-1){1'b0}}, 1'b1};
        rd_en   = !shift_done;
      end
      pal_pkg::RD_POS: begin
        raddr_c = pos_r;
        rd_en   = 1'b1;
      end
      default: begin
        raddr_c = pos_r;
        rd_en   = 1'b0;
      end
    endcase
  end

  // Memory write data and enable
  logic                  wr_en;
  logic [DATA_WIDTH-1:0] wdata;
  assign wr_en = (ctl.cw.wr != pal_pkg::WR_NONE);
  assign wdata = (ctl.cw.wr == pal_pkg::WR_VALUE) ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[idx_r[AW-1:0]] <= wdata;
    if (rd_en)
      rdata_r <= mem[raddr_c[AW-1:0]];
  end

  // Index and count updates
  always_comb begin
    case (ctl.cw.idx)
      pal_pkg::IDX_COUNT: idx_nxt = count_r;
      pal_pkg::IDX_POS:   idx_nxt = pos_r;
      pal_pkg::IDX_INC:   idx_nxt = idx_r + {{(CW-1){1'b0}}, 1'b1};
      pal_pkg::IDX_DEC:   idx_nxt = idx_r - {{(CW-1){1'b0}}, 1'b1};
      default:            idx_nxt = idx_r;
    endcase
    case (ctl.cw.cnt)
      pal_pkg::CNT_INC:   count_nxt = count_r + {{(CW-1){1'b0}}, 1'b1};
      pal_pkg::CNT_DEC:   count_nxt = count_r - {{(CW-1){1'b0}}, 1'b1};
      pal_pkg::CNT_CLEAR: count_nxt = '0;
      default:            count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      count_r <= '0;
    else
      count_r <= count_nxt;
  end

  // Transaction capture; position clamped so insert past end appends
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.accept) begin
      act_r    <= in_item.action;
      pos_r    <= CW'(pos_clamp_k);
      val_r    <= in_data;
      status_r <= chk_status;
    end
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
    end
    if (ctl.finish) begin
      out_item_r.status     <= status_r;
      out_item_r.read_value <= (act_r == pal_pkg::ACT_GET && status_r == pal_pkg::ST_OK)
                               ? rd_wide[31:0] : 32'd0;
      out_item_r.length     <= cnt_k[4:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/pal_checker.sv =====
// Port-level checks for positional_array_list, attached by bind.
// Depends on pal_pkg for the result transaction type.
module pal_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input pal_pkg::out_item_t out_item
);

  // An accepted transaction holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // Result is a single-cycle strobe
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Result appears only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Every busy period ends with a result
  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // Failed transactions read back zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != pal_pkg::ST_OK)) |-> (out_item.read_value == 32'd0))
    else $error("nonzero read data on failed transaction");

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== sim/tb.sv =====
// Testbench for positional_array_list: directed and random list commands with a
// scoreboard fed by a behavioral list predictor, plus capacity writes over APB.
// Depends on rtl/core/pal_pkg.sv and rtl/core/positional_array_list.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIST_DEPTH    = 16;
  localparam int          MAX_CYCLES    = 400000;
  localparam int          DRAIN_CYCLES  = 40;
  localparam logic [2:0]  CAPACITY_ADDR = 3'd0;   // register 0 at byte address 0
  localparam int          IDLE_PCT      = 34;

  // DUT connections
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  pal_pkg::in_item_t   in_item = '0;
  logic                out_valid;
  pal_pkg::out_item_t  out_item;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Predicted list state
  logic [31:0] cells [LIST_DEPTH];
  int          list_len = 0;
  logic [4:0]  cap_limit = pal_pkg::CAPACITY_RESET;

  // Command and result bookkeeping
  pal_pkg::in_item_t   cmd_queue[$];
  pal_pkg::out_item_t  expected_results[$];
  pal_pkg::out_item_t  want;
  int          n_accepted = 0;
  int          n_results = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          longest_list = 0;

  positional_array_list u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one command to the predicted list and return the expected result
  function automatic pal_pkg::out_item_t list_apply(input pal_pkg::in_item_t cmd);
    pal_pkg::out_item_t res;
    int        eff_cap;
    int        slot;
    int        i;
    res.status     = pal_pkg::ST_OK;
    res.read_value = '0;
    eff_cap = (int'(cap_limit) > LIST_DEPTH) ? LIST_DEPTH : int'(cap_limit);
    slot    = int'(cmd.position);
    case (cmd.action)
      pal_pkg::ACT_INSERT: begin
        if (cmd.entry_value == '0) begin
          res.status = pal_pkg::ST_NULL;
        end else if (list_len >= eff_cap) begin
          res.status = pal_pkg::ST_FULL;
        end else begin
          // past the end means append
          if (slot > list_len) slot = list_len;
          for (i = list_len; i > slot; i--) cells[i] = cells[i-1];
          cells[slot] = cmd.entry_value;
          list_len++;
        end
      end
      pal_pkg::ACT_GET: begin
        if (slot >= list_len) res.status = pal_pkg::ST_RANGE;
        else res.read_value = cells[slot];
      end
      pal_pkg::ACT_DELETE: begin
        if (slot >= list_len) begin
          res.status = pal_pkg::ST_RANGE;
        end else begin
          for (i = slot; i + 1 < list_len; i++) cells[i] = cells[i+1];
          list_len--;
        end
      end
      default: begin
        // clear keeps cell contents, they just become unreachable
        list_len = 0;
      end
    endcase
    res.length = list_len[4:0];
    return res;
  endfunction

  function automatic pal_pkg::in_item_t mk_cmd(input pal_pkg::action_t a,
                                               input logic [4:0] p,
                                               input logic [31:0] v);
    pal_pkg::in_item_t c;
    c.action      = a;
    c.position    = p;
    c.entry_value = v;
    return c;
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 32'h0;
    if (r < 10) return 32'hFFFF_FFFF;
    if (r < 14) return 32'h0000_0001;
    return $urandom;
  endfunction

  function automatic logic [4:0] rand_position();
    if ($urandom_range(0, 99) < 85) return 5'($urandom_range(0, 17));
    return 5'($urandom_range(0, 31));
  endfunction

  // Fill run of inserts to reach capacity, then a mixed command stream
  task automatic queue_random(input int n_mixed);
    pal_pkg::action_t a;
    int      r;
    repeat (LIST_DEPTH + 2) begin
      cmd_queue.push_back(mk_cmd(pal_pkg::ACT_INSERT, rand_position(), rand_value()));
    end
    repeat (n_mixed) begin
      r = $urandom_range(0, 99);
      if (r < 45) a = pal_pkg::ACT_INSERT;
      else if (r < 79) a = pal_pkg::ACT_GET;
      else if (r < 97) a = pal_pkg::ACT_DELETE;
      else a = pal_pkg::ACT_CLEAR;
      cmd_queue.push_back(mk_cmd(a, rand_position(), rand_value()));
    end
  endtask

  // Wait until no command is pending and the block has gone idle
  task automatic wait_drained();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || start || busy || expected_results.size() != 0);
  endtask

  // APB write of capacity, then read it back
  task automatic write_capacity(input logic [4:0] cap);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= {27'($urandom), cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_limit = cap;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[4:0] !== cap) begin
      mismatches++;
      if (mismatches <= 10)
        $display("capacity readback: expected %0d, got %0d", cap, prdata[4:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: hands out queued commands, idles at random outside the burst window
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(list_apply(in_item));
        n_accepted++;
        if (list_len > longest_list) longest_list = list_len;
      end
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 &&
            ((n_accepted >= 200 && n_accepted < 280) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          start   <= 1'b1;
          in_item <= cmd_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result strobe against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d data %h length %0d",
                   out_item.status, out_item.read_value, out_item.length);
      end else begin
        want = expected_results.pop_front();
        n_results++;
        status_seen[want.status]++;
        if (out_item.status !== want.status || out_item.read_value !== want.read_value ||
            out_item.length !== want.length) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d mismatch: expected st %0d data %h len %0d, ",
                      "got st %0d data %h len %0d"},
                     n_results, want.status, want.read_value, want.length,
                     out_item.status, out_item.read_value, out_item.length);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [4:0] cap_plan [6];
    cap_plan = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd7, 5'($urandom_range(2, 15))};

    // directed: empty list, null insert, appends, middle moves, range edges, clear
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd0,  32'h1234_5678));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_DELETE, 5'd0,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_INSERT, 5'd0,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_INSERT, 5'd31, 32'hFFFF_FFFF));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_INSERT, 5'd0,  32'h0000_0001));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_INSERT, 5'd1,  32'h8000_0000));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_INSERT, 5'd3,  32'h5A5A_A5A5));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_INSERT, 5'd16, 32'h7FFF_FFFE));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd0,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd1,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd2,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd4,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd5,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd31, 32'hFFFF_FFFF));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_DELETE, 5'd1,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_DELETE, 5'd3,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_DELETE, 5'd3,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_DELETE, 5'd31, 32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd2,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_CLEAR,  5'd31, 32'hFFFF_FFFF));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd0,  32'h0));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_INSERT, 5'd5,  32'hDEAD_0001));
    cmd_queue.push_back(mk_cmd(pal_pkg::ACT_GET,    5'd0,  32'h0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // default capacity first, then each written setting
    queue_random(36);
    wait_drained();
    foreach (cap_plan[k]) begin
      write_capacity(cap_plan[k]);
      queue_random(36);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d ok, %0d null, %0d full, %0d out of range",
             n_accepted, status_seen[pal_pkg::ST_OK], status_seen[pal_pkg::ST_NULL],
             status_seen[pal_pkg::ST_FULL], status_seen[pal_pkg::ST_RANGE]);
    $display("capacities 16, 1, 0, 31, 16, 7 and %0d; longest list %0d entries",
             cap_plan[5], longest_list);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pal_pkg.sv
rtl/core/pal_sequencer.sv
rtl/core/pal_datapath.sv
rtl/core/positional_array_list.sv
rtl/core/pal_checker.sv
sim/tb.sv
